FILE: src/lcdsr_pkg.sv
package lcdsr_pkg;

    localparam int NUM_CHARS_DEF   = 32;
    localparam int LINE_LENGTH_DEF = 16;

    localparam int POS_W  = 5;
    localparam int CHAR_W = 8;
    localparam int DDRAM_W = 7;

    localparam logic [DDRAM_W-1:0] ADDR_LINE_ODD   = 7'h40;
    localparam logic [DDRAM_W-1:0] ADDR_MASK       = 7'h7f;
    localparam logic [CHAR_W-1:0]  CMD_SET_ADDRESS = 8'h80;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_CURSOR = 2'd2
    } cmd_t;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] char_code;
        logic              lcd_busy;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] lcd_byte;
        logic              register_select;
    } result_t;

endpackage

FILE: src/lcdsr_ram.sv
module lcdsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/lcdsr_prio_enc.sv
module lcdsr_prio_enc #(
    parameter int N = 32
) (
    input  logic [N-1:0]         bits,
    output logic                 any,
    output logic [$clog2(N)-1:0] index
);

    localparam int IW = $clog2(N);

    always_comb
    begin
        any   = 1'b0;
        index = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                any   = 1'b1;
                index = IW'(i);
            end
        end
    end

endmodule

FILE: src/lcd_shadow_refresh_engine.sv
// Shadow-buffer refresh engine for a multi-line character display. Write and
// set-cursor commands, and ticks that find the display busy, are handled in
// S_IDLE and give no result. A tick with the display ready goes on to S_EMIT:
// in S_IDLE it searches the dirty bits and reads the character memory at the
// lowest dirty position, in S_EMIT it decides on an address command or a data
// byte. A result shows up on the cycle after that, held on result for exactly
// one cycle with result_valid high; there is no way to hold it off, so the
// receiver must take it on that cycle. The character memory needs no clearing
// after reset, so items are taken from the first cycle out of reset.
module lcd_shadow_refresh_engine
    import lcdsr_pkg::*;
#(
    parameter int NUM_CHARS   = NUM_CHARS_DEF,
    parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    result_valid,
    output result_t result
);

    localparam int PW = $clog2(NUM_CHARS);
    localparam int TW = $clog2(NUM_CHARS + 1);
    localparam logic [TW-1:0] ADDR_UNKNOWN = TW'(NUM_CHARS);

    typedef logic [NUM_CHARS-1:0][DDRAM_W-1:0] addr_table_t;

    function automatic addr_table_t build_addr_table();
        addr_table_t tbl;
        int col;
        int line;
        int addr;
        col  = 0;
        line = 0;
        for (int p = 0; p < NUM_CHARS; p++)
        begin
            addr = col + (line >> 1) * LINE_LENGTH + ((line % 2) * int'(ADDR_LINE_ODD));
            tbl[p] = DDRAM_W'(addr) & ADDR_MASK;
            if (col == LINE_LENGTH - 1)
            begin
                col  = 0;
                line = line + 1;
            end
            else
            begin
                col = col + 1;
            end
        end
        return tbl;
    endfunction

    function automatic logic [NUM_CHARS-1:0] build_eol_table();
        logic [NUM_CHARS-1:0] tbl;
        for (int p = 0; p < NUM_CHARS; p++)
        begin
            tbl[p] = (p == NUM_CHARS - 1) || (((p + 1) % LINE_LENGTH) == 0);
        end
        return tbl;
    endfunction

    localparam addr_table_t          ADDR_TABLE = build_addr_table();
    localparam logic [NUM_CHARS-1:0] EOL_TABLE  = build_eol_table();

    state_t               state_reg, state_next;
    logic [NUM_CHARS-1:0] dirty_reg, dirty_next;
    logic [TW-1:0]        tracked_reg, tracked_next;
    logic [PW-1:0]        resting_reg, resting_next;
    logic [PW-1:0]        found_reg, found_next;
    logic                 any_reg, any_next;
    logic                 result_valid_reg, result_valid_next;
    result_t              result_reg, result_next;

    logic                 accept;
    logic                 pos_ok;
    logic [PW-1:0]        pos_idx;
    logic                 search_any;
    logic [PW-1:0]        search_idx;
    logic                 mem_we;
    logic [CHAR_W-1:0]    mem_rdata;
    logic                 go_emit;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign pos_ok  = (int'(item.position) < NUM_CHARS);
    assign pos_idx = PW'(item.position);
    assign mem_we  = accept && (item.command == CMD_WRITE) && pos_ok;
    assign go_emit = accept && (item.command == CMD_TICK) && !item.lcd_busy;

    lcdsr_prio_enc #(
        .N(NUM_CHARS)
    ) u_prio_enc (
        .bits (dirty_reg),
        .any  (search_any),
        .index(search_idx)
    );

    lcdsr_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(NUM_CHARS)
    ) u_char_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(pos_idx),
        .wdata(item.char_code),
        .raddr(search_idx),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go_emit)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dirty_next        = dirty_reg;
        tracked_next      = tracked_reg;
        resting_next      = resting_reg;
        found_next        = found_reg;
        any_next          = any_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.command)
                        CMD_WRITE:
                        begin
                            if (pos_ok)
                            begin
                                dirty_next[pos_idx] = 1'b1;
                            end
                        end
                        CMD_CURSOR:
                        begin
                            if (pos_ok)
                            begin
                                resting_next = pos_idx;
                            end
                        end
                        CMD_TICK:
                        begin
                            found_next = search_idx;
                            any_next   = search_any;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (any_reg)
                begin
                    if (tracked_reg != TW'(found_reg))
                    begin
                        tracked_next                = TW'(found_reg);
                        result_valid_next           = 1'b1;
                        result_next.lcd_byte        = CMD_SET_ADDRESS
                                                      | CHAR_W'(ADDR_TABLE[found_reg]);
                        result_next.register_select = RS_COMMAND;
                    end
                    else
                    begin
                        dirty_next[found_reg] = 1'b0;
                        if (EOL_TABLE[found_reg])
                        begin
                            tracked_next = ADDR_UNKNOWN;
                        end
                        else
                        begin
                            tracked_next = TW'(found_reg) + TW'(1);
                        end
                        result_valid_next           = 1'b1;
                        result_next.lcd_byte        = mem_rdata;
                        result_next.register_select = RS_DATA;
                    end
                end
                else if (tracked_reg != TW'(resting_reg))
                begin
                    tracked_next                = TW'(resting_reg);
                    result_valid_next           = 1'b1;
                    result_next.lcd_byte        = CMD_SET_ADDRESS
                                                  | CHAR_W'(ADDR_TABLE[resting_reg]);
                    result_next.register_select = RS_COMMAND;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            dirty_reg        <= '0;
            tracked_reg      <= '0;
            resting_reg      <= '0;
            any_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            dirty_reg        <= dirty_next;
            tracked_reg      <= tracked_next;
            resting_reg      <= resting_next;
            any_reg          <= any_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
